@@ hw/rtl/tpdc_pkg.sv @@
// tpdc_pkg: shared types and constants of the triaxial peak density counter
// no dependencies; imported by tpdc_lane and triaxial_peak_density_counter_top
`default_nettype none

package tpdc_pkg;

	localparam int SampleW = 16;
	localparam int CountW  = 16;
	localparam int ThreshW = 10;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 16;

	// register indexes of the configuration port
	localparam logic [CfgIdxW-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_WINDOW    = 2'd1;

	// reset values: threshold 307/256 ~ 1.20, window of 500 samples
	localparam logic [ThreshW-1:0] THRESHOLD_RESET = 10'd307;
	localparam logic [CountW-1:0]  WINDOW_RESET    = 16'd500;

	typedef logic signed [SampleW-1:0] sample_t;
	typedef logic [CountW-1:0] count_t;
	typedef logic [ThreshW-1:0] thresh_t;

	typedef struct packed {
		sample_t accel_x;
		sample_t accel_y;
		sample_t accel_z;
	} in_word_t;

	typedef struct packed {
		count_t peak_count_x;
		count_t peak_count_y;
		count_t peak_count_z;
	} out_word_t;

	// per-sample control shared by the three lanes
	typedef struct packed {
		logic step;   // a sample is consumed this cycle
		logic test;   // window holds at least three samples, peak test is live
		logic clear;  // window closes, totals restart at zero
	} lane_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/triaxial_peak_density_counter_top.sv @@
// triaxial_peak_density_counter_top: window control, config registers, word registers
// depends on tpdc_pkg and tpdc_lane
`default_nettype none

// channel | direction | handshake            | word
// in      | input     | in_valid / in_stall  | in_word_t: accel_x, accel_y, accel_z
// out     | output    | out_valid / out_stall| out_word_t: peak_count_x/y/z
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one sample word per cycle while in_stall is low: a word is held in the input
// register, the three lane compares and the window count run on it there, and a
// closing window lands in the output register as the word leaves the input register
// reset clears the counters, histories and valid bits; config takes its defaults
// a waiting output word only holds back the input when the word in the input
// register would close another window

module triaxial_peak_density_counter_top
	import tpdc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	// sample words
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire in_word_t            in_word,
	// window totals
	output logic                     out_valid,
	input  wire logic                out_stall,
	output out_word_t                out_word,
	// configuration writes
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);

	// config registers
	thresh_t threshold_q;
	count_t  window_q;

	// input register
	logic     valid_s1;
	in_word_t word_s1;

	// window state and output register
	count_t    sample_count_q;
	logic      out_valid_q;
	out_word_t out_word_q;

	count_t     count_next;
	logic       emit;
	logic       advance;
	lane_ctrl_t ctrl;
	count_t     cnt_x;
	count_t     cnt_y;
	count_t     cnt_z;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
			window_q    <= WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_THRESHOLD: threshold_q <= cfg_data[ThreshW-1:0];
				CFG_WINDOW:    window_q    <= cfg_data;
				default: ;  // unused index, write dropped
			endcase
		end
	end

	// window count wraps modulo 2^16
	assign count_next = sample_count_q + count_t'(1);
	assign emit       = (count_next == window_q);

	// the word in s1 moves on unless it would close a window onto a held output
	assign advance  = valid_s1 && !(emit && out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= in_word;
		end
	end

	// peak test only once three samples are in the window
	assign ctrl.step  = advance;
	assign ctrl.test  = (count_next > count_t'(2));
	assign ctrl.clear = emit;

	tpdc_lane u_lane_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.threshold (threshold_q),
		.sample    (word_s1.accel_x),
		.count     (cnt_x)
	);

	tpdc_lane u_lane_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.threshold (threshold_q),
		.sample    (word_s1.accel_y),
		.count     (cnt_y)
	);

	tpdc_lane u_lane_z (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.threshold (threshold_q),
		.sample    (word_s1.accel_z),
		.count     (cnt_z)
	);

	// a closed window restarts the count at one, not zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= '0;
		end else if (advance) begin
			sample_count_q <= emit ? count_t'(1) : count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_word_q.peak_count_x <= cnt_x;
			out_word_q.peak_count_y <= cnt_y;
			out_word_q.peak_count_z <= cnt_z;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

`default_nettype wire

@@ hw/rtl/tpdc_lane.sv @@
// tpdc_lane: one axis, two-sample history, peak compare and saturating total
// depends on tpdc_pkg
`default_nettype none

module tpdc_lane
	import tpdc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire lane_ctrl_t ctrl,
	input  wire thresh_t    threshold,
	input  wire sample_t    sample,
	output count_t          count
);

	sample_t hist0_q;  // oldest
	sample_t hist1_q;  // middle
	count_t  acc_q;

	logic signed [26:0] mid_scaled;
	logic signed [26:0] left_prod;
	logic signed [26:0] right_prod;
	logic signed [26:0] thr_ext;
	logic               peak;

	assign thr_ext    = 27'(signed'({1'b0, threshold}));
	assign mid_scaled = 27'(hist1_q) <<< 8;
	assign left_prod  = 27'(hist0_q) * thr_ext;
	assign right_prod = 27'(sample) * thr_ext;
	assign peak       = (mid_scaled > left_prod) && (mid_scaled > right_prod);

	// total including this sample, saturating
	assign count = (ctrl.test && peak && (acc_q != '1)) ? acc_q + count_t'(1) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist0_q <= '0;
			hist1_q <= '0;
			acc_q   <= '0;
		end else if (ctrl.step) begin
			hist0_q <= hist1_q;
			hist1_q <= sample;
			acc_q   <= ctrl.clear ? '0 : count;
		end
	end

endmodule

`default_nettype wire
